// File: rtl/hrlp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrlp_pkg
// Shared types, character codes and lookup tables of the request line parser.
// ----------------------------------------------------------------------------
package hrlp_pkg;

  localparam logic [7:0] CHAR_SP    = 8'h20;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_PCT   = 8'h25;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_QMARK = 8'h3F;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  localparam int CMD_BYTES        = 4;
  localparam int DEFAULT_PATH_LEN = 11;

  localparam logic ITEM_PATH    = 1'b0;
  localparam logic ITEM_VERDICT = 1'b1;

  typedef enum logic [1:0] {
    VERDICT_OK         = 2'd0,
    VERDICT_MALFORMED  = 2'd1,
    VERDICT_BAD_METHOD = 2'd2
  } verdict_t;

  typedef enum logic [2:0] {
    PH_METHOD = 3'd0,
    PH_PATH   = 3'd1,
    PH_QUERY  = 3'd2,
    PH_REST   = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  // work handed from the front end to the back end for one input item
  typedef struct packed {
    logic [CMD_BYTES-1:0][7:0] bytes;
    logic [2:0]                nbytes;
    logic                      dflt;
    logic                      has_verdict;
    verdict_t                  verdict;
  } cmd_t;

  function automatic logic [7:0] default_path_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h2F; // /
      4'd1:    c = 8'h69; // i
      4'd2:    c = 8'h6E; // n
      4'd3:    c = 8'h64; // d
      4'd4:    c = 8'h65; // e
      4'd5:    c = 8'h78; // x
      4'd6:    c = 8'h2E; // .
      4'd7:    c = 8'h68; // h
      4'd8:    c = 8'h74; // t
      4'd9:    c = 8'h6D; // m
      4'd10:   c = 8'h6C; // l
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] method_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h47; // G
      2'd1:    c = 8'h45; // E
      2'd2:    c = 8'h54; // T
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// File: rtl/http_request_line_path_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// http_request_line_path_parser
// Parses the request line of one HTTP request and streams the decoded path
// followed by a verdict item.
// ----------------------------------------------------------------------------
// One request byte is accepted per cycle while full is low. The front end
// parses it in the cycle it is accepted and queues a command in a four-entry
// command queue; the back end turns each command into result items at one item
// per cycle while the consumer keeps up: a byte that decodes to one path byte
// yields one item, a closing space that expands an empty path to /index.html
// yields eleven, and end_of_request adds one verdict item. Input stalls (full
// high) only when the queue fills behind a slow consumer or multi-item commands
// such as a default path expansion.
// Path bytes are speculative: keep them only when the verdict is ok.
module http_request_line_path_parser #(
  parameter int MAX_REQUEST_BYTES = 4095,
  parameter int CMD_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte,
  input  wire logic        byte_present,
  input  wire logic        end_of_request,
  output logic             empty,
  input  wire logic        pop,
  output logic             item_kind,
  output logic [7:0]       path_byte,
  output logic [1:0]       verdict,
  output logic             final_item
);

  logic           take;
  hrlp_pkg::cmd_t cmd;
  logic           cmd_valid;
  hrlp_pkg::cmd_t head;
  logic           head_empty;
  logic           head_pop;
  logic           out_valid;

  assign take  = push && !full;
  assign empty = !out_valid;

  hrlp_front #(
    .MAX_REQUEST_BYTES(MAX_REQUEST_BYTES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .data_byte     (data_byte),
    .byte_present  (byte_present),
    .end_of_request(end_of_request),
    .cmd           (cmd),
    .cmd_valid     (cmd_valid)
  );

  hrlp_cmd_fifo #(
    .DEPTH(CMD_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_valid),
    .push_data(cmd),
    .full     (full),
    .pop      (head_pop),
    .head     (head),
    .empty    (head_empty)
  );

  hrlp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .head_empty(head_empty),
    .head_pop  (head_pop),
    .out_valid (out_valid),
    .out_take  (pop),
    .item_kind (item_kind),
    .path_byte (path_byte),
    .verdict   (verdict),
    .final_item(final_item)
  );

  a_reset_clears: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("outputs not idle after reset");

  a_verdict_item: assert property (@(posedge clk) disable iff (rst)
    !empty && item_kind == hrlp_pkg::ITEM_VERDICT |-> final_item && path_byte == 8'h00)
    else $error("verdict item malformed");

  a_path_item: assert property (@(posedge clk) disable iff (rst)
    !empty && item_kind == hrlp_pkg::ITEM_PATH |->
      !final_item && verdict == hrlp_pkg::VERDICT_OK)
    else $error("path item carries verdict fields");

  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    !empty |-> verdict <= hrlp_pkg::VERDICT_BAD_METHOD)
    else $error("undefined verdict code");

endmodule
`default_nettype wire

// File: rtl/hrlp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrlp_front
// Parses one request byte per cycle while take is high, tracks the line state
// and issues a command with the decoded bytes, default path and verdict it causes.
// ----------------------------------------------------------------------------
module hrlp_front #(
  parameter int MAX_REQUEST_BYTES = 4095
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          take,
  input  wire logic [7:0]    data_byte,
  input  wire logic          byte_present,
  input  wire logic          end_of_request,
  output hrlp_pkg::cmd_t     cmd,
  output logic               cmd_valid
);

  localparam int CNT_W = $clog2(MAX_REQUEST_BYTES + 1);

  typedef struct packed {
    hrlp_pkg::phase_t phase;
    logic             method_matches;
    logic [2:0]       method_length;
    logic [1:0]       spaces_seen;
    logic [7:0]       esc_hold;
    logic [1:0]       esc_cnt;
    logic             slash_held;
    logic             emitted;
    logic             prev_cr;
    logic             line_complete;
  } state_t;

  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] b;
    logic            dflt;
  } emit_t;

  localparam state_t ST_RESET = '{
    phase:          hrlp_pkg::PH_METHOD,
    method_matches: 1'b1,
    method_length:  3'd0,
    spaces_seen:    2'd0,
    esc_hold:       8'h00,
    esc_cnt:        2'd0,
    slash_held:     1'b0,
    emitted:        1'b0,
    prev_cr:        1'b0,
    line_complete:  1'b0
  };

  state_t           st;
  state_t           st_next;
  logic [CNT_W-1:0] bytes_taken;
  logic [CNT_W-1:0] bytes_taken_next;

  // {valid, value}
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  function automatic void put(inout emit_t e, input logic [7:0] v);
    e.b[e.cnt] = v;
    e.cnt = e.cnt + 2'd1;
  endfunction

  function automatic void flush_escape(inout state_t s, inout emit_t e);
    if (s.esc_cnt >= 2'd1) put(e, hrlp_pkg::CHAR_PCT);
    if (s.esc_cnt >= 2'd2) put(e, s.esc_hold);
    s.esc_cnt = 2'd0;
  endfunction

  function automatic void path_char(inout state_t s, inout emit_t e, input logic [7:0] b);
    logic       consumed;
    logic [4:0] hb;
    logic [4:0] hh;
    consumed = 1'b0;
    hb = hex_nibble(b);
    hh = hex_nibble(s.esc_hold);
    if (!s.emitted && !s.slash_held && b == hrlp_pkg::CHAR_SLASH) begin
      s.slash_held = 1'b1;
    end else begin
      if (s.slash_held) begin
        put(e, hrlp_pkg::CHAR_SLASH);
        s.slash_held = 1'b0;
      end
      s.emitted = 1'b1;
      if (s.esc_cnt == 2'd1) begin
        if (hb[4]) begin
          s.esc_hold = b;
          s.esc_cnt = 2'd2;
          consumed = 1'b1;
        end else begin
          flush_escape(s, e);
        end
      end else if (s.esc_cnt == 2'd2) begin
        if (hb[4]) begin
          put(e, {hh[3:0], hb[3:0]});
          s.esc_cnt = 2'd0;
          consumed = 1'b1;
        end else begin
          flush_escape(s, e);
        end
      end
      if (!consumed) begin
        if (b == hrlp_pkg::CHAR_PCT) s.esc_cnt = 2'd1;
        else if (b == hrlp_pkg::CHAR_PLUS) put(e, hrlp_pkg::CHAR_SP);
        else put(e, b);
      end
    end
  endfunction

  function automatic void path_end(inout state_t s, inout emit_t e);
    flush_escape(s, e);
    if (!s.emitted) begin
      e.dflt = 1'b1;
      s.emitted = 1'b1;
    end
    s.slash_held = 1'b0;
  endfunction

  function automatic void line_byte(inout state_t s, inout emit_t e, input logic [7:0] b);
    case (s.phase)
      hrlp_pkg::PH_METHOD: begin
        if (b == hrlp_pkg::CHAR_SP) begin
          s.method_matches = s.method_matches && (s.method_length == 3'd3);
          s.spaces_seen = 2'd1;
          s.phase = hrlp_pkg::PH_PATH;
        end else begin
          if (s.method_length >= 3'd3 ||
              b != hrlp_pkg::method_char(s.method_length[1:0])) begin
            s.method_matches = 1'b0;
          end
          if (s.method_length < 3'd4) s.method_length = s.method_length + 3'd1;
        end
      end
      hrlp_pkg::PH_PATH: begin
        if (b == hrlp_pkg::CHAR_SP) begin
          path_end(s, e);
          s.spaces_seen = 2'd2;
          s.phase = hrlp_pkg::PH_REST;
        end else if (b == hrlp_pkg::CHAR_QMARK) begin
          path_end(s, e);
          s.phase = hrlp_pkg::PH_QUERY;
        end else begin
          path_char(s, e, b);
        end
      end
      hrlp_pkg::PH_QUERY: begin
        if (b == hrlp_pkg::CHAR_SP) begin
          s.spaces_seen = 2'd2;
          s.phase = hrlp_pkg::PH_REST;
        end
      end
      default: begin
      end
    endcase
  endfunction

  state_t     s;
  emit_t      e1;
  emit_t      e2;
  logic [2:0] j;

  always_comb begin
    s = st;
    e1 = '0;
    e2 = '0;
    bytes_taken_next = bytes_taken;
    if (byte_present && bytes_taken < CNT_W'(MAX_REQUEST_BYTES)) begin
      bytes_taken_next = bytes_taken + CNT_W'(1);
      if (s.phase != hrlp_pkg::PH_DONE) begin
        if (s.prev_cr && data_byte == hrlp_pkg::CHAR_LF) begin
          s.prev_cr = 1'b0;
          s.line_complete = 1'b1;
          s.phase = hrlp_pkg::PH_DONE;
        end else begin
          // a lone cr is an ordinary line byte
          if (s.prev_cr) begin
            s.prev_cr = 1'b0;
            line_byte(s, e1, hrlp_pkg::CHAR_CR);
          end
          if (data_byte == hrlp_pkg::CHAR_CR) s.prev_cr = 1'b1;
          else line_byte(s, e2, data_byte);
        end
      end
    end

    cmd = '0;
    for (int i = 0; i < hrlp_pkg::CMD_BYTES; i++) begin
      j = 3'(i) - {1'b0, e1.cnt};
      if (3'(i) < {1'b0, e1.cnt}) cmd.bytes[i] = e1.b[i[1:0]];
      else if (j < 3'd3) cmd.bytes[i] = e2.b[j[1:0]];
    end
    cmd.nbytes = {1'b0, e1.cnt} + {1'b0, e2.cnt};
    cmd.dflt = e1.dflt | e2.dflt;
    cmd.has_verdict = end_of_request;
    if (!s.line_complete || s.spaces_seen != 2'd2) cmd.verdict = hrlp_pkg::VERDICT_MALFORMED;
    else if (!s.method_matches) cmd.verdict = hrlp_pkg::VERDICT_BAD_METHOD;
    else cmd.verdict = hrlp_pkg::VERDICT_OK;

    cmd_valid = take && (cmd.nbytes != 3'd0 || cmd.dflt || end_of_request);

    st_next = end_of_request ? ST_RESET : s;
    if (end_of_request) bytes_taken_next = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_RESET;
      bytes_taken <= '0;
    end else if (take) begin
      st <= st_next;
      bytes_taken <= bytes_taken_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/hrlp_cmd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrlp_cmd_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module hrlp_cmd_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire hrlp_pkg::cmd_t push_data,
  output logic                full,
  input  wire logic           pop,
  output hrlp_pkg::cmd_t      head,
  output logic                empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hrlp_pkg::cmd_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) count <= count + CNT_W'(1);
      else if (do_pop && !do_push) count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

endmodule
`default_nettype wire

// File: rtl/hrlp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrlp_back
// Expands each command into result items in the output register, one per
// cycle while that register is free or being taken.
// ----------------------------------------------------------------------------
module hrlp_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire hrlp_pkg::cmd_t head,
  input  wire logic           head_empty,
  output logic                head_pop,
  output logic                out_valid,
  input  wire logic           out_take,
  output logic                item_kind,
  output logic [7:0]          path_byte,
  output logic [1:0]          verdict,
  output logic                final_item
);

  hrlp_pkg::cmd_t cur;
  logic           cur_valid;
  logic [3:0]     step;
  logic [3:0]     dstep;
  logic [4:0]     total;
  logic           last;
  logic           issue;
  logic           load;
  logic           nxt_kind;
  logic [7:0]     nxt_byte;
  logic [1:0]     nxt_verdict;

  always_comb begin
    total = 5'({2'b00, cur.nbytes}) + (cur.dflt ? 5'(hrlp_pkg::DEFAULT_PATH_LEN) : 5'd0)
          + {4'd0, cur.has_verdict};
    last  = ({1'b0, step} + 5'd1) == total;
    dstep = step - {1'b0, cur.nbytes};

    nxt_kind    = hrlp_pkg::ITEM_PATH;
    nxt_byte    = 8'h00;
    nxt_verdict = hrlp_pkg::VERDICT_OK;
    if (step < {1'b0, cur.nbytes}) begin
      nxt_byte = cur.bytes[step[1:0]];
    end else if (cur.dflt && dstep < 4'(hrlp_pkg::DEFAULT_PATH_LEN)) begin
      nxt_byte = hrlp_pkg::default_path_char(dstep);
    end else begin
      nxt_kind    = hrlp_pkg::ITEM_VERDICT;
      nxt_verdict = cur.verdict;
    end
  end

  // the output register frees up on the same edge it is taken
  assign issue    = cur_valid && (!out_valid || out_take);
  assign load     = !cur_valid || (issue && last);
  assign head_pop = load && !head_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
      step <= '0;
    end else begin
      if (issue) out_valid <= 1'b1;
      else if (out_take) out_valid <= 1'b0;
      if (load) begin
        cur_valid <= !head_empty;
        step <= '0;
      end else if (issue) begin
        step <= step + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (head_pop) cur <= head;
    if (issue) begin
      item_kind  <= nxt_kind;
      path_byte  <= nxt_byte;
      verdict    <= nxt_verdict;
      final_item <= (nxt_kind == hrlp_pkg::ITEM_VERDICT);
    end
  end

endmodule
`default_nettype wire
